>>> sv/lit_pkg.sv
// Package for the linear interpolation table: sizes, codes and beat types.
// Used by lit_front, lit_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lit_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ENTRY_W    = 64;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_INTERIOR = 3'd0,
        ST_EXTRAP   = 3'd1,
        ST_CLAMPED  = 3'd2,
        ST_NOSEG    = 3'd3,
        ST_LOADED   = 3'd4,
        ST_ZEROW    = 3'd5
    } t_status;

    typedef struct packed {
        t_opcode            opcode;
        logic [5:0]         entry_index;
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
        logic signed [31:0] query_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        t_status            status;
    } t_out_item;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_queue_head;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A1,
        S_A2,
        S_A3,
        S_A4,
        S_SC0,
        S_SCAN,
        S_CHK,
        S_MUL,
        S_DIV,
        S_FIN,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

>>> sv/lit_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stands alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none
module lit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> sv/lit_front.sv
// Front end: accepts input beats into a two-entry queue ahead of the back end.
// Depends on lit_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lit_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire lit_pkg::t_in_item i_data,
    output logic                  o_stall,
    output lit_pkg::t_queue_head  o_head,
    input  wire logic             i_pop
);

    lit_pkg::t_in_item r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_pop && (r_cnt != 2'd0);
    assign o_head  = '{valid: (r_cnt != 2'd0), item: r_mem[r_rp]};

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule
`default_nettype wire

>>> sv/lit_back.sv
// Back end: table writes, breakpoint scan, shift-add multiply, restoring divide.
// Depends on lit_pkg and lit_ram.
`timescale 1ns / 1ps
`default_nettype none
module lit_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lit_pkg::t_queue_head i_head,
    output logic                     o_pop,
    input  wire logic                i_cfg_valid,
    input  wire logic [6:0]          i_cfg_data,
    output logic                     o_valid,
    output lit_pkg::t_out_item       o_data,
    input  wire logic                i_stall
);

    lit_pkg::t_state             r_state, n_state;
    logic [6:0]                  r_points;
    logic [lit_pkg::CNT_W-1:0]   r_n, n_n;
    logic [lit_pkg::CNT_W-1:0]   r_k, n_k;
    logic signed [31:0]          r_q, n_q;
    logic signed [31:0]          r_ax, n_ax;
    logic signed [31:0]          r_ay, n_ay;
    logic signed [31:0]          r_xb, n_xb;
    logic signed [31:0]          r_yb, n_yb;
    logic signed [32:0]          r_dx, n_dx;
    logic signed [32:0]          r_dy, n_dy;
    logic                        r_extrap, n_extrap;
    logic                        r_neg, n_neg;
    logic [65:0]                 r_acc, n_acc;
    logic [32:0]                 r_mpl, n_mpl;
    logic [32:0]                 r_mcand, n_mcand;
    logic [32:0]                 r_div, n_div;
    logic [32:0]                 r_rem, n_rem;
    logic [6:0]                  r_cnt, n_cnt;
    lit_pkg::t_out_item          r_res, n_res;
    logic                        r_ovalid;
    lit_pkg::t_out_item          r_odata;

    logic                        w_we;
    logic [lit_pkg::ADDR_W-1:0]  w_raddr;
    logic [lit_pkg::ENTRY_W-1:0] w_rdata;
    logic signed [31:0]          w_rd_x;
    logic signed [31:0]          w_rd_y;
    logic                        w_out_free;
    logic [lit_pkg::CNT_W-1:0]   w_n_eff;
    logic signed [32:0]          w_dq;
    logic [33:0]                 w_rem_sh;
    logic [34:0]                 w_diff;
    logic [34:0]                 w_m;
    logic [36:0]                 w_t;
    logic [36:0]                 w_v;

    lit_ram #(
        .WIDTH(lit_pkg::ENTRY_W),
        .DEPTH(lit_pkg::MAX_POINTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(lit_pkg::ADDR_W'(i_head.item.entry_index)),
        .i_wdata({i_head.item.entry_x, i_head.item.entry_y}),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd_x     = w_rdata[63:32];
    assign w_rd_y     = w_rdata[31:0];
    assign w_out_free = !r_ovalid || !i_stall;

    always_comb begin
        if (r_points < 7'd2) begin
            w_n_eff = lit_pkg::CNT_W'(2);
        end else if (32'(r_points) > lit_pkg::MAX_POINTS) begin
            w_n_eff = lit_pkg::CNT_W'(lit_pkg::MAX_POINTS);
        end else begin
            w_n_eff = lit_pkg::CNT_W'(r_points);
        end
    end

    assign w_dq     = {r_q[31], r_q} - {r_xb[31], r_xb};
    assign w_rem_sh = {r_rem, r_acc[65]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_div};
    assign w_m      = ((|r_acc[65:35]) || (r_acc[34] && (|r_acc[33:0])))
                      ? {1'b1, 34'd0} : r_acc[34:0];
    assign w_t      = r_neg ? -{2'b00, w_m} : {2'b00, w_m};
    assign w_v      = {{5{r_yb[31]}}, r_yb} + w_t;

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_k      = r_k;
        n_q      = r_q;
        n_ax     = r_ax;
        n_ay     = r_ay;
        n_xb     = r_xb;
        n_yb     = r_yb;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_extrap = r_extrap;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_mpl    = r_mpl;
        n_mcand  = r_mcand;
        n_div    = r_div;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_res    = r_res;
        o_pop    = 1'b0;
        w_we     = 1'b0;
        w_raddr  = '0;
        unique case (r_state)
            lit_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.item.opcode == lit_pkg::OP_LOAD) begin
                        w_we = (32'(i_head.item.entry_index) < lit_pkg::MAX_POINTS);
                        n_res.result_value = '0;
                        n_res.status       = lit_pkg::ST_LOADED;
                        n_state            = lit_pkg::S_EMIT;
                    end else begin
                        n_q     = i_head.item.query_value;
                        n_n     = w_n_eff;
                        n_state = lit_pkg::S_A1;
                    end
                end
            end
            lit_pkg::S_A1: begin
                w_raddr = lit_pkg::ADDR_W'(1);
                n_ax    = w_rd_x;
                n_ay    = w_rd_y;
                n_state = lit_pkg::S_A2;
            end
            lit_pkg::S_A2: begin
                if (r_q <= r_ax) begin
                    n_xb     = r_ax;
                    n_yb     = r_ay;
                    n_dx     = {w_rd_x[31], w_rd_x} - {r_ax[31], r_ax};
                    n_dy     = {w_rd_y[31], w_rd_y} - {r_ay[31], r_ay};
                    n_extrap = 1'b1;
                    n_state  = lit_pkg::S_CHK;
                end else begin
                    w_raddr = lit_pkg::ADDR_W'(r_n - lit_pkg::CNT_W'(2));
                    n_state = lit_pkg::S_A3;
                end
            end
            lit_pkg::S_A3: begin
                w_raddr = lit_pkg::ADDR_W'(r_n - lit_pkg::CNT_W'(1));
                n_ax    = w_rd_x;
                n_ay    = w_rd_y;
                n_state = lit_pkg::S_A4;
            end
            lit_pkg::S_A4: begin
                if (r_q >= w_rd_x) begin
                    n_xb     = w_rd_x;
                    n_yb     = w_rd_y;
                    n_dx     = {w_rd_x[31], w_rd_x} - {r_ax[31], r_ax};
                    n_dy     = {w_rd_y[31], w_rd_y} - {r_ay[31], r_ay};
                    n_extrap = 1'b1;
                    n_state  = lit_pkg::S_CHK;
                end else begin
                    n_state = lit_pkg::S_SC0;
                end
            end
            lit_pkg::S_SC0: begin
                w_raddr = lit_pkg::ADDR_W'(1);
                n_ax    = w_rd_x;
                n_ay    = w_rd_y;
                n_k     = lit_pkg::CNT_W'(1);
                n_state = lit_pkg::S_SCAN;
            end
            lit_pkg::S_SCAN: begin
                if (r_q == r_ax) begin
                    n_res.result_value = r_ay;
                    n_res.status       = lit_pkg::ST_INTERIOR;
                    n_state            = lit_pkg::S_EMIT;
                end else if (r_q < w_rd_x) begin
                    n_xb     = r_ax;
                    n_yb     = r_ay;
                    n_dx     = {w_rd_x[31], w_rd_x} - {r_ax[31], r_ax};
                    n_dy     = {w_rd_y[31], w_rd_y} - {r_ay[31], r_ay};
                    n_extrap = 1'b0;
                    n_state  = lit_pkg::S_CHK;
                end else if (r_k == r_n - lit_pkg::CNT_W'(1)) begin
                    n_res.result_value = '0;
                    n_res.status       = lit_pkg::ST_NOSEG;
                    n_state            = lit_pkg::S_EMIT;
                end else begin
                    w_raddr = lit_pkg::ADDR_W'(r_k + lit_pkg::CNT_W'(1));
                    n_ax    = w_rd_x;
                    n_ay    = w_rd_y;
                    n_k     = r_k + lit_pkg::CNT_W'(1);
                end
            end
            lit_pkg::S_CHK: begin
                if (r_dx == '0) begin
                    n_res.result_value = '0;
                    n_res.status       = lit_pkg::ST_ZEROW;
                    n_state            = lit_pkg::S_EMIT;
                end else begin
                    n_neg   = (r_dy[32] ^ w_dq[32]) ^ r_dx[32];
                    n_mcand = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
                    n_mpl   = w_dq[32] ? 33'(-w_dq) : 33'(w_dq);
                    n_div   = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = lit_pkg::S_MUL;
                end
            end
            lit_pkg::S_MUL: begin
                n_acc = {r_acc[64:0], 1'b0} + (r_mpl[32] ? {33'd0, r_mcand} : 66'd0);
                n_mpl = {r_mpl[31:0], 1'b0};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd32) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = lit_pkg::S_DIV;
                end
            end
            lit_pkg::S_DIV: begin
                if (!w_diff[34]) begin
                    n_rem = w_diff[32:0];
                    n_acc = {r_acc[64:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh[32:0];
                    n_acc = {r_acc[64:0], 1'b0};
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd65) begin
                    n_state = lit_pkg::S_FIN;
                end
            end
            lit_pkg::S_FIN: begin
                if (r_extrap && (w_v[36] || (w_v == '0))) begin
                    n_res.result_value = '0;
                    n_res.status       = lit_pkg::ST_CLAMPED;
                end else begin
                    if (!w_v[36] && (|w_v[35:31])) begin
                        n_res.result_value = 32'sh7FFF_FFFF;
                    end else if (w_v[36] && !(&w_v[35:31])) begin
                        n_res.result_value = 32'sh8000_0000;
                    end else begin
                        n_res.result_value = w_v[31:0];
                    end
                    n_res.status = r_extrap ? lit_pkg::ST_EXTRAP : lit_pkg::ST_INTERIOR;
                end
                n_state = lit_pkg::S_EMIT;
            end
            lit_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_state = lit_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lit_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lit_pkg::S_IDLE;
            r_points <= 7'd2;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_points <= i_cfg_data;
            end
            if (r_state == lit_pkg::S_EMIT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_k      <= n_k;
        r_q      <= n_q;
        r_ax     <= n_ax;
        r_ay     <= n_ay;
        r_xb     <= n_xb;
        r_yb     <= n_yb;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_extrap <= n_extrap;
        r_neg    <= n_neg;
        r_acc    <= n_acc;
        r_mpl    <= n_mpl;
        r_mcand  <= n_mcand;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
        if (r_state == lit_pkg::S_EMIT && w_out_free) begin
            r_odata <= r_res;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == lit_pkg::S_IDLE))
        else $error("queue popped outside idle");
    a_we_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (o_pop && i_head.item.opcode == lit_pkg::OP_LOAD))
        else $error("table written without a load");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lit_pkg::S_DIV) |-> (r_div != '0))
        else $error("divide by zero width");
    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lit_pkg::S_EMIT && w_out_free) |=> o_valid)
        else $error("result not presented");

endmodule
`default_nettype wire

>>> sv/linear_interp_table.sv
// Top level of the piecewise linear interpolation table.
// Depends on lit_pkg, lit_front, lit_back and lit_ram.
//
//   channel | handshake                   | beat
//   input   | i_valid / o_stall           | lit_pkg::t_in_item
//   output  | o_valid / i_stall           | lit_pkg::t_out_item
//   config  | i_cfg_valid / o_cfg_ready   | points_in_use, 7 bits
//
// The time a query takes is set by the table scan (up to 63 breakpoints, one per
// cycle through the RAM read port) and by the 33-step multiply and the 66-step
// divide that run one after the other.
// Reset is synchronous and active low; the table contents are not cleared.
// Two input beats queue while the back end works; output stalls hold the result.
`timescale 1ns / 1ps
`default_nettype none
module linear_interp_table (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire lit_pkg::t_in_item i_data,
    output logic                   o_stall,
    output logic                   o_valid,
    output lit_pkg::t_out_item     o_data,
    input  wire logic              i_stall,
    input  wire logic              i_cfg_valid,
    input  wire logic [6:0]        i_cfg_data,
    output logic                   o_cfg_ready
);

    lit_pkg::t_queue_head w_head;
    logic                 w_pop;

    assign o_cfg_ready = 1'b1;

    lit_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_data (i_data),
        .o_stall(o_stall),
        .o_head (w_head),
        .i_pop  (w_pop)
    );

    lit_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .i_cfg_valid(i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

endmodule
`default_nettype wire
